// ===== sv/pms_pkg.sv =====
// ----------------------------------------------------------------------------
// pms_pkg
// Shared types, constants and helper functions of the plant model step block.
// ----------------------------------------------------------------------------
package pms_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_COEF_A  = 3'd0;
    localparam logic [2:0] CFG_COEF_B  = 3'd1;
    localparam logic [2:0] CFG_COEF_C  = 3'd2;
    localparam logic [2:0] CFG_COEF_D  = 3'd3;
    localparam logic [2:0] CFG_INIT_Y  = 3'd4;
    localparam logic [2:0] CFG_INIT_U  = 3'd5;

    // Angle constants in Q4.30
    localparam logic signed [33:0] TWO_PI_Q30  = 34'sd6746518852;
    localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

    // Product sequence of one step on the shared multiplier
    typedef enum logic [2:0] {
        OP_A_YL,
        OP_B_U,
        OP_YP_SQ,
        OP_A_YN,
        OP_B_SQ,
        OP_C_U,
        OP_D_SIN
    } op_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       capture;
        logic       setup;
        logic       mod_step;
        logic       fold;
        logic       cordic_step;
        logic       mul;
        logic       acc;
        logic       finish;
        op_t        op;
        logic [4:0] step;
    } cmd_t;

    typedef struct packed {
        logic        flag;
        logic [31:0] value;
    } sat_t;

    // Clip a wide signed value to 32 bits
    function automatic sat_t sat32(input logic signed [63:0] v);
        sat_t r;
        if (v > 64'sd2147483647) begin
            r.flag  = 1'b1;
            r.value = 32'h7FFF_FFFF;
        end
        else if (v < -64'sd2147483648) begin
            r.flag  = 1'b1;
            r.value = 32'h8000_0000;
        end
        else begin
            r.flag  = 1'b0;
            r.value = v[31:0];
        end
        return r;
    endfunction

    // Arctangent of 2^-i in Q2.30
    function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
        logic signed [33:0] r;
        case (i)
            5'd0:  r = 34'sd843314857;
            5'd1:  r = 34'sd497837829;
            5'd2:  r = 34'sd263043836;
            5'd3:  r = 34'sd133525158;
            5'd4:  r = 34'sd67021686;
            5'd5:  r = 34'sd33543515;
            5'd6:  r = 34'sd16775850;
            5'd7:  r = 34'sd8388437;
            5'd8:  r = 34'sd4194282;
            5'd9:  r = 34'sd2097149;
            5'd10: r = 34'sd1048575;
            5'd11: r = 34'sd524287;
            5'd12: r = 34'sd262143;
            5'd13: r = 34'sd131071;
            5'd14: r = 34'sd65535;
            5'd15: r = 34'sd32767;
            5'd16: r = 34'sd16383;
            5'd17: r = 34'sd8191;
            5'd18: r = 34'sd4095;
            5'd19: r = 34'sd2047;
            5'd20: r = 34'sd1023;
            5'd21: r = 34'sd511;
            5'd22: r = 34'sd255;
            5'd23: r = 34'sd127;
            5'd24: r = 34'sd63;
            5'd25: r = 34'sd31;
            5'd26: r = 34'sd15;
            5'd27: r = 34'sd8;
            5'd28: r = 34'sd4;
            5'd29: r = 34'sd2;
            5'd30: r = 34'sd1;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/pms_ctrl.sv =====
// ----------------------------------------------------------------------------
// pms_ctrl
// Step sequencer: angle reduction, CORDIC rotation, multiply/accumulate
// sequence and result hand-off, plus the input and output handshakes.
// ----------------------------------------------------------------------------
module pms_ctrl
    import pms_pkg::*;
#(
    parameter int REDUCE_TOP   = 6,
    parameter int CORDIC_STEPS = 24
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_REDUCE,
        ST_FOLD,
        ST_ROTATE,
        ST_MUL,
        ST_ACC,
        ST_FINISH
    } state_t;

    state_t     state_reg;
    logic [4:0] step_reg;
    op_t        op_reg;
    logic       out_valid_reg;
    logic       can_finish;

    // Decode state into datapath commands
    always_comb
    begin
        in_ready        = (state_reg == ST_IDLE);
        out_valid       = out_valid_reg;
        can_finish      = !out_valid_reg || out_ready;
        cmd.capture     = (state_reg == ST_IDLE) && in_valid;
        cmd.setup       = (state_reg == ST_SETUP);
        cmd.mod_step    = (state_reg == ST_REDUCE);
        cmd.fold        = (state_reg == ST_FOLD);
        cmd.cordic_step = (state_reg == ST_ROTATE);
        cmd.mul         = (state_reg == ST_MUL);
        cmd.acc         = (state_reg == ST_ACC);
        cmd.finish      = (state_reg == ST_FINISH) && can_finish;
        cmd.op          = op_reg;
        cmd.step        = step_reg;
    end

    // Hold state, counters and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            op_reg        <= OP_A_YL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                        state_reg <= ST_SETUP;
                end
                ST_SETUP:
                begin
                    step_reg  <= 5'(REDUCE_TOP);
                    state_reg <= ST_REDUCE;
                end
                ST_REDUCE:
                begin
                    if (step_reg == 5'd0)
                        state_reg <= ST_FOLD;
                    else
                        step_reg <= step_reg - 5'd1;
                end
                ST_FOLD:
                begin
                    step_reg  <= '0;
                    state_reg <= ST_ROTATE;
                end
                ST_ROTATE:
                begin
                    if (step_reg == 5'(CORDIC_STEPS - 1))
                    begin
                        op_reg    <= OP_A_YL;
                        state_reg <= ST_MUL;
                    end
                    else
                        step_reg <= step_reg + 5'd1;
                end
                ST_MUL:
                begin
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    if (op_reg == OP_D_SIN)
                        state_reg <= ST_FINISH;
                    else
                    begin
                        op_reg    <= op_t'(op_reg + 3'd1);
                        state_reg <= ST_MUL;
                    end
                end
                ST_FINISH:
                begin
                    if (can_finish)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while a step is in flight");

    a_finish_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid)
        else $error("finished step did not present a result");

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.setup, cmd.mod_step, cmd.fold,
                  cmd.cordic_step, cmd.mul, cmd.acc, cmd.finish}))
        else $error("more than one datapath command at once");
`endif

endmodule

// ===== sv/pms_dpath.sv =====
// ----------------------------------------------------------------------------
// pms_dpath
// Datapath: configuration registers, plant state, angle reduction, CORDIC
// sine, one shared 32x32 multiplier with accumulator, and result registers.
// ----------------------------------------------------------------------------
module pms_dpath
    import pms_pkg::*;
#(
    parameter int FRAC_BITS = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic [31:0] drive_sample,
    output logic [31:0] linear_output,
    output logic [31:0] nonlinear_output,
    output logic        saturated
);

    localparam int ANG_SHIFT = 30 - FRAC_BITS;

    logic signed [31:0] coef_a_reg, coef_b_reg, coef_c_reg, coef_d_reg;
    logic signed [31:0] init_y_reg, init_u_reg;
    logic               primed_reg;
    logic signed [31:0] lin_state_reg, nl_state_reg, nl_prior_reg, prior_drive_reg;
    logic signed [31:0] u_reg;

    logic               neg_reg;
    logic [63:0]        mag_reg;
    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic signed [31:0] sin_reg;

    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic signed [31:0] sq_reg, lin_reg, nl_reg;
    logic               flag_reg;

    logic [31:0]        out_lin_reg, out_nl_reg;
    logic               out_sat_reg;

    logic signed [63:0] z_full;
    logic [63:0]        mod_sub;
    logic signed [33:0] r0, r1, r2, z0;
    logic signed [33:0] dx, dy, ang;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] term;
    logic signed [63:0] sum;
    sat_t               sat_term, sat_sum;

    // Scale the previous drive into Q34.30 and shift the modulus for this step
    always_comb
    begin
        z_full  = 64'(prior_drive_reg) <<< ANG_SHIFT;
        mod_sub = {30'b0, TWO_PI_Q30} << cmd.step;
    end

    // Map the remainder into (-pi, pi] and fold into [-pi/2, pi/2]
    always_comb
    begin
        r0 = mag_reg[33:0];
        r1 = (neg_reg && (r0 != 34'sd0)) ? TWO_PI_Q30 - r0 : r0;
        r2 = (r1 > PI_Q30) ? r1 - TWO_PI_Q30 : r1;
        if (r2 > HALF_PI_Q30)
            z0 = PI_Q30 - r2;
        else if (r2 < -HALF_PI_Q30)
            z0 = -PI_Q30 - r2;
        else
            z0 = r2;
    end

    // CORDIC micro-rotation terms
    always_comb
    begin
        dx  = cy_reg >>> cmd.step;
        dy  = cx_reg >>> cmd.step;
        ang = atan_q30(cmd.step);
    end

    // Select multiplier operands
    always_comb
    begin
        case (cmd.op)
            OP_A_YL:  begin mul_a = coef_a_reg;   mul_b = lin_state_reg; end
            OP_B_U:   begin mul_a = coef_b_reg;   mul_b = u_reg;         end
            OP_YP_SQ: begin mul_a = nl_prior_reg; mul_b = nl_prior_reg;  end
            OP_A_YN:  begin mul_a = coef_a_reg;   mul_b = nl_state_reg;  end
            OP_B_SQ:  begin mul_a = coef_b_reg;   mul_b = sq_reg;        end
            OP_C_U:   begin mul_a = coef_c_reg;   mul_b = u_reg;         end
            OP_D_SIN: begin mul_a = coef_d_reg;   mul_b = sin_reg;       end
            default:  begin mul_a = '0;           mul_b = '0;            end
        endcase
    end

    // Scale the product back and form the accumulator update
    always_comb
    begin
        term = prod_reg >>> FRAC_BITS;
        case (cmd.op)
            OP_B_SQ: sum = acc_reg - term;
            default: sum = acc_reg + term;
        endcase
        sat_term = sat32(term);
        sat_sum  = sat32(sum);
    end

    // Configuration registers and plant state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg      <= '0;
            coef_b_reg      <= '0;
            coef_c_reg      <= '0;
            coef_d_reg      <= '0;
            init_y_reg      <= '0;
            init_u_reg      <= '0;
            primed_reg      <= 1'b0;
            lin_state_reg   <= '0;
            nl_state_reg    <= '0;
            nl_prior_reg    <= '0;
            prior_drive_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_COEF_A: begin coef_a_reg <= cfg_data; primed_reg <= 1'b0; end
                    CFG_COEF_B: begin coef_b_reg <= cfg_data; primed_reg <= 1'b0; end
                    CFG_COEF_C: begin coef_c_reg <= cfg_data; primed_reg <= 1'b0; end
                    CFG_COEF_D: begin coef_d_reg <= cfg_data; primed_reg <= 1'b0; end
                    CFG_INIT_Y: begin init_y_reg <= cfg_data; primed_reg <= 1'b0; end
                    CFG_INIT_U: begin init_u_reg <= cfg_data; primed_reg <= 1'b0; end
                    default:    begin end
                endcase
            end
            // Load starting state on the first step after reset or a write to registers 0 to 5
            if (cmd.capture && !primed_reg)
            begin
                lin_state_reg   <= init_y_reg;
                nl_state_reg    <= init_y_reg;
                nl_prior_reg    <= init_y_reg;
                prior_drive_reg <= init_u_reg;
                primed_reg      <= 1'b1;
            end
            // Advance the plant state
            if (cmd.finish)
            begin
                lin_state_reg   <= lin_reg;
                nl_prior_reg    <= nl_state_reg;
                nl_state_reg    <= nl_reg;
                prior_drive_reg <= u_reg;
            end
        end
    end

    // Working registers of one step
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            u_reg    <= drive_sample;
            flag_reg <= 1'b0;
        end
        if (cmd.setup)
        begin
            neg_reg <= z_full[63];
            mag_reg <= z_full[63] ? 64'(-z_full) : 64'(z_full);
        end
        // Restoring reduction, one shifted modulus per cycle
        if (cmd.mod_step && (mag_reg >= mod_sub))
            mag_reg <= mag_reg - mod_sub;
        if (cmd.fold)
        begin
            cx_reg <= GAIN_Q30;
            cy_reg <= '0;
            cz_reg <= z0;
        end
        if (cmd.cordic_step)
        begin
            if (!cz_reg[33])
            begin
                cx_reg <= cx_reg - dx;
                cy_reg <= cy_reg + dy;
                cz_reg <= cz_reg - ang;
            end
            else
            begin
                cx_reg <= cx_reg + dx;
                cy_reg <= cy_reg - dy;
                cz_reg <= cz_reg + ang;
            end
        end
        if (cmd.mul)
        begin
            sin_reg  <= 32'(cy_reg >>> ANG_SHIFT);
            prod_reg <= 64'(mul_a) * 64'(mul_b);
        end
        if (cmd.acc)
        begin
            case (cmd.op)
                OP_A_YL, OP_A_YN:
                    acc_reg <= term;
                OP_B_U:
                begin
                    lin_reg  <= sat_sum.value;
                    flag_reg <= flag_reg | sat_sum.flag;
                end
                OP_YP_SQ:
                begin
                    sq_reg   <= sat_term.value;
                    flag_reg <= flag_reg | sat_term.flag;
                end
                OP_D_SIN:
                begin
                    nl_reg   <= sat_sum.value;
                    flag_reg <= flag_reg | sat_sum.flag;
                end
                default:
                    acc_reg <= sum;
            endcase
        end
        if (cmd.finish)
        begin
            out_lin_reg <= lin_reg;
            out_nl_reg  <= nl_reg;
            out_sat_reg <= flag_reg;
        end
    end

    assign linear_output    = out_lin_reg;
    assign nonlinear_output = out_nl_reg;
    assign saturated        = out_sat_reg;

endmodule

// ===== sv/plant_model_step.sv =====
// ----------------------------------------------------------------------------
// plant_model_step
// Advances a linear first-order plant and a nonlinear plant by one drive sample.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries drive_sample (signed Q8.24).
//   Each transfer yields one result on out_valid/out_ready: linear_output,
//   nonlinear_output (both saturated) and saturated, the clip flag.
//   Configuration channel cfg_valid/cfg_ready writes cfg_data to register
//   cfg_index: 0 coef_a, 1 coef_b, 2 coef_c, 3 coef_d, 4 initial_output,
//   5 initial_drive; other indexes are dropped. cfg_ready is always high.
//   Any accepted write to indexes 0 to 5 makes the next step reload the
//   plant state from initial_output and initial_drive.
// Occupancy:
//   One item is worked on at a time; the next input can be taken in the
//   cycle after the finish. The cost of a step is the one-bit-per-cycle
//   angle reduction, the CORDIC iterations and seven products through one
//   shared multiplier.
// Reset clears the configuration registers and plant state; the first step
// then loads its starting state. A stalled receiver holds the result in the
// output register; the next item is still taken and waits before its finish.
// ----------------------------------------------------------------------------
module plant_model_step
    import pms_pkg::*;
#(
    parameter int FRAC_BITS    = 24,
    parameter int CORDIC_STEPS = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] drive_sample,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] linear_output,
    output logic [31:0] nonlinear_output,
    output logic        saturated,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cmd_t cmd;

    assign cfg_ready = 1'b1;

    // Sequence the step
    pms_ctrl #(
        .REDUCE_TOP   (30 - FRAC_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // Compute the step
    pms_dpath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .cfg_we           (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .drive_sample     (drive_sample),
        .linear_output    (linear_output),
        .nonlinear_output (nonlinear_output),
        .saturated        (saturated)
    );

endmodule
